[rtl/crcfc_pkg.sv]
// ----------------------------------------------------------------------------
// crcfc_pkg - shared types and constants for the CRC32C frame checker
// Frame layout constants, status codes, result item type and the byte-wide
// CRC32C update function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crcfc_pkg;

  // Frame layout
  localparam int HDR_BYTES = 10;
  localparam int CRC_BYTES = 4;
  localparam int MIN_FRAME = 14;
  localparam int POS_W     = 33;
  localparam int CFG_IDX_W = 8;

  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [31:0]      CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0]      CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0]      MAX_BODY_RESET = 32'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MAGIC   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_SIZE = 8'd1;

  // Verdict status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_CRC_BAD   = 3'd5;

  // One result item
  typedef struct packed {
    logic [7:0]  body_byte;
    logic        is_verdict;
    logic [2:0]  status;
    logic [15:0] msg_type;
  } result_t;

  // Reflected CRC32C update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/crcfc_out_queue.sv]
// ----------------------------------------------------------------------------
// crcfc_out_queue - four-entry result queue
// Takes up to two result items per cycle and hands out one per cycle on a
// valid/stall channel. Reports room when at least two entries are free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcfc_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_a,
  input  wire crcfc_pkg::result_t item_a,
  input  wire logic              push_b,
  input  wire crcfc_pkg::result_t item_b,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output crcfc_pkg::result_t     out_item
);

  crcfc_pkg::result_t entry_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [2:0] n_push;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign out_item  = entry_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  // Pointer and fill bookkeeping; item b only rides along with item a
  always_comb begin
    n_push     = {2'd0, push_a} + {2'd0, push_a & push_b};
    wr_ptr_nxt = wr_ptr_r + n_push[1:0];
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + n_push - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push_a) begin
      entry_r[wr_ptr_r] <= item_a;
    end
    if (push_a && push_b) begin
      entry_r[wr_ptr_r + 2'd1] <= item_b;
    end
  end

endmodule

`default_nettype wire

[rtl/crc32c_frame_checker_core.sv]
// ----------------------------------------------------------------------------
// crc32c_frame_checker_core - streaming check of a length-prefixed CRC32C frame
// Parses magic, type and length, passes body bytes when the length is within
// max_body_size, and issues a verdict with type and status on the buffer's last byte.
// ----------------------------------------------------------------------------
// Queueing: a result item is written to the result queue when its byte is accepted.
// Throughput: one byte per cycle; the frame state and the byte-wide CRC32C
//   update are done in the accept cycle. A last byte that is also an emitted
//   body byte yields two items, drained one per cycle by the four-entry queue
//   when out_stall is low; input stalls while fewer than two queue entries are free.
// Reset: synchronous active-low rst_n clears frame state and the queue and
//   loads frame_magic = 0, max_body_size = 65536.
`timescale 1ns / 1ps
`default_nettype none

module crc32c_frame_checker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_buffer,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_body_byte,
  output logic             out_is_verdict,
  output logic [2:0]       out_status,
  output logic [15:0]      out_msg_type,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [crcfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int PW = crcfc_pkg::POS_W;

  // Configuration registers
  logic [31:0] frame_magic_r;
  logic [31:0] max_body_r;

  // Frame state
  logic [PW-1:0] pos_r, pos_nxt;
  logic [31:0]   hdr_shift_r, hdr_shift_nxt;
  logic          magic_ok_r, magic_ok_nxt;
  logic [15:0]   type_r, type_nxt;
  logic [31:0]   length_r, length_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic [31:0]   rx_crc_r, rx_crc_nxt;

  logic          in_accept;
  logic          room;
  logic [PW-1:0] body_end;
  logic [PW:0]   crc_end;
  logic [PW+1:0] frame_len;
  logic [1:0]    crc_ofs;
  logic          body_emit;
  logic [2:0]    status;
  logic [15:0]   vtype;
  logic          push_a, push_b;
  crcfc_pkg::result_t item_a, item_b, body_item, verdict_item, out_item;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~room;
  assign in_accept = in_valid & ~in_stall;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_magic_r <= 32'd0;
      max_body_r    <= crcfc_pkg::MAX_BODY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crcfc_pkg::REG_FRAME_MAGIC:   frame_magic_r <= cfg_data;
        crcfc_pkg::REG_MAX_BODY_SIZE: max_body_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame field tracking for the current byte
  always_comb begin
    body_end = PW'(crcfc_pkg::HDR_BYTES) + {1'b0, length_r};
    crc_end  = {1'b0, body_end} + (PW+1)'(crcfc_pkg::CRC_BYTES);
    crc_ofs  = pos_r[1:0] - body_end[1:0];

    hdr_shift_nxt = hdr_shift_r;
    magic_ok_nxt  = magic_ok_r;
    type_nxt      = type_r;
    length_nxt    = length_r;
    crc_nxt       = crc_r;
    rx_crc_nxt    = rx_crc_r;
    body_emit     = 1'b0;

    if (pos_r < PW'(crcfc_pkg::HDR_BYTES)) begin
      crc_nxt       = crcfc_pkg::crc_byte(crc_r, in_data_byte);
      hdr_shift_nxt = {in_data_byte, hdr_shift_r[31:8]};
      if (pos_r == PW'(3)) begin
        magic_ok_nxt = (hdr_shift_nxt == frame_magic_r);
      end else if (pos_r == PW'(4) || pos_r == PW'(5)) begin
        type_nxt = {in_data_byte, type_r[15:8]};
      end else if (pos_r >= PW'(6)) begin
        length_nxt = {in_data_byte, length_r[31:8]};
      end
    end else if (pos_r < body_end) begin
      crc_nxt   = crcfc_pkg::crc_byte(crc_r, in_data_byte);
      body_emit = (length_r <= max_body_r);
    end else if ({1'b0, pos_r} < crc_end) begin
      case (crc_ofs)
        2'd0:    rx_crc_nxt = rx_crc_r | {24'd0, in_data_byte};
        2'd1:    rx_crc_nxt = rx_crc_r | {16'd0, in_data_byte, 8'd0};
        2'd2:    rx_crc_nxt = rx_crc_r | {8'd0, in_data_byte, 16'd0};
        default: rx_crc_nxt = rx_crc_r | {in_data_byte, 24'd0};
      endcase
    end

    pos_nxt = (pos_r == crcfc_pkg::POS_MAX) ? pos_r : pos_r + PW'(1);
  end

  // Verdict from the state as it stands after this byte
  always_comb begin
    frame_len = (PW+2)'(crcfc_pkg::MIN_FRAME) + {2'd0, length_nxt};
    vtype     = 16'd0;
    if (pos_nxt < PW'(crcfc_pkg::MIN_FRAME)) begin
      status = crcfc_pkg::ST_SHORT;
    end else if (!magic_ok_nxt) begin
      status = crcfc_pkg::ST_BAD_MAGIC;
    end else begin
      vtype = type_nxt;
      if (frame_len > {2'd0, pos_nxt}) begin
        status = crcfc_pkg::ST_TRUNC;
      end else if (length_nxt > max_body_r) begin
        status = crcfc_pkg::ST_TOO_LONG;
      end else if (rx_crc_nxt != ~crc_nxt) begin
        status = crcfc_pkg::ST_CRC_BAD;
      end else begin
        status = crcfc_pkg::ST_OK;
      end
    end
  end

  // Result items: body item first, verdict after it
  always_comb begin
    body_item            = '0;
    body_item.body_byte  = in_data_byte;
    verdict_item            = '0;
    verdict_item.is_verdict = 1'b1;
    verdict_item.status     = status;
    verdict_item.msg_type   = vtype;

    push_a = in_accept & (body_emit | in_end_of_buffer);
    push_b = in_accept & body_emit & in_end_of_buffer;
    item_a = body_emit ? body_item : verdict_item;
    item_b = verdict_item;
  end

  // Frame state registers; cleared after a verdict
  always_ff @(posedge clk) begin
    if (!rst_n || (in_accept && in_end_of_buffer)) begin
      pos_r       <= '0;
      hdr_shift_r <= 32'd0;
      magic_ok_r  <= 1'b0;
      type_r      <= 16'd0;
      length_r    <= 32'd0;
      crc_r       <= crcfc_pkg::CRC_INIT;
      rx_crc_r    <= 32'd0;
    end else if (in_accept) begin
      pos_r       <= pos_nxt;
      hdr_shift_r <= hdr_shift_nxt;
      magic_ok_r  <= magic_ok_nxt;
      type_r      <= type_nxt;
      length_r    <= length_nxt;
      crc_r       <= crc_nxt;
      rx_crc_r    <= rx_crc_nxt;
    end
  end

  // Result queue
  crcfc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .item_a    (item_a),
    .push_b    (push_b),
    .item_b    (item_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_body_byte  = out_item.body_byte;
  assign out_is_verdict = out_item.is_verdict;
  assign out_status     = out_item.status;
  assign out_msg_type   = out_item.msg_type;

endmodule

`default_nettype wire
